FILE: sv/assert_macros.svh
// Assertion helper macros used by the checker file.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/hcid_pkg.sv
// Shared types and constants for the HCI UART packet deframer.
// No dependencies.
`default_nettype none

package hcid_pkg;

   // Frame capacity in bytes; positions saturate one below it.
   localparam int FRAME_CAPACITY = 1024;
   localparam int SEEN_W         = $clog2(FRAME_CAPACITY + 1);
   localparam int POS_W          = 10;
   localparam int LEN_W          = 16;

   // H4 packet indicator bytes
   localparam logic [7:0] IND_CMD   = 8'h01;
   localparam logic [7:0] IND_ACL   = 8'h02;
   localparam logic [7:0] IND_EVT   = 8'h04;
   localparam logic [7:0] IND_LOCAL = 8'h20;

   // Header byte numbers (counted from 1) that carry the length
   localparam logic [SEEN_W-1:0] EVT_LEN_BYTE    = SEEN_W'(3);
   localparam logic [SEEN_W-1:0] CMD_LEN_BYTE    = SEEN_W'(4);
   localparam logic [SEEN_W-1:0] ACL_LEN_LO_BYTE = SEEN_W'(4);
   localparam logic [SEEN_W-1:0] ACL_LEN_HI_BYTE = SEEN_W'(5);

   localparam logic [SEEN_W-1:0] SEEN_CAP = SEEN_W'(FRAME_CAPACITY);
   localparam logic [SEEN_W-1:0] SEEN_TOP = SEEN_W'(FRAME_CAPACITY - 1);

   typedef enum logic [1:0] {
      KIND_CMD   = 2'd0,
      KIND_ACL   = 2'd1,
      KIND_EVT   = 2'd2,
      KIND_LOCAL = 2'd3
   } kind_type;

   // One result beat
   typedef struct packed {
      logic [7:0]       out_byte;
      logic             in_frame;
      logic [1:0]       packet_kind;
      logic [POS_W-1:0] byte_position;
      logic             frame_last;
      logic             overflow;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/hcid_tracker.sv
// Frame state tracker: phase, kind, byte count and payload countdown.
// Depends on hcid_pkg. Produces the result for the byte in the input register.
`default_nettype none

module hcid_tracker (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic [7:0]      byte_in,
   output hcid_pkg::rsp_type    result
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type                         phase_ff, phase_in;
   hcid_pkg::kind_type                kind_ff, kind_in;
   logic [hcid_pkg::SEEN_W-1:0]       seen_ff, seen_in;
   logic [hcid_pkg::LEN_W-1:0]        left_ff, left_in;

   logic [hcid_pkg::SEEN_W-1:0]       seen_inc;
   logic [hcid_pkg::SEEN_W-1:0]       offset;
   logic [hcid_pkg::SEEN_W-1:0]       pos_full;
   logic [hcid_pkg::LEN_W-1:0]        left_dec;
   logic [hcid_pkg::LEN_W-1:0]        len_val;
   logic                              len_byte;
   logic                              acl_lo_byte;
   logic                              known;
   hcid_pkg::kind_type                kind_dec;
   logic                              last;

   // Saturating byte count
   assign seen_inc = (seen_ff < hcid_pkg::SEEN_CAP) ? seen_ff + 1'b1 : seen_ff;
   assign left_dec = left_ff - 1'b1;

   // Indicator decode
   always_comb begin
      known    = 1'b1;
      kind_dec = hcid_pkg::KIND_CMD;
      unique case (byte_in)
         hcid_pkg::IND_CMD:   kind_dec = hcid_pkg::KIND_CMD;
         hcid_pkg::IND_ACL:   kind_dec = hcid_pkg::KIND_ACL;
         hcid_pkg::IND_EVT:   kind_dec = hcid_pkg::KIND_EVT;
         hcid_pkg::IND_LOCAL: kind_dec = hcid_pkg::KIND_LOCAL;
         default:             known    = 1'b0;
      endcase
   end

   // Header byte roles
   always_comb begin
      acl_lo_byte = (kind_ff == hcid_pkg::KIND_ACL) && (seen_inc == hcid_pkg::ACL_LEN_LO_BYTE);
      len_byte    = ((kind_ff == hcid_pkg::KIND_ACL) &&
                     (seen_inc == hcid_pkg::ACL_LEN_HI_BYTE)) ||
                    ((kind_ff == hcid_pkg::KIND_EVT) &&
                     (seen_inc == hcid_pkg::EVT_LEN_BYTE)) ||
                    (((kind_ff == hcid_pkg::KIND_CMD) || (kind_ff == hcid_pkg::KIND_LOCAL)) &&
                     (seen_inc == hcid_pkg::CMD_LEN_BYTE));
      len_val     = (kind_ff == hcid_pkg::KIND_ACL) ? {byte_in, left_ff[7:0]}
                                                    : {8'h00, byte_in};
   end

   // Next state and result
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      seen_in  = seen_ff;
      left_in  = left_ff;
      offset   = seen_ff;
      last     = 1'b0;
      result   = '0;
      result.out_byte = byte_in;
      result.in_frame = 1'b1;
      result.packet_kind = kind_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            seen_in = seen_inc;
            if (acl_lo_byte) begin
               left_in = {8'h00, byte_in};
            end else if (len_byte) begin
               left_in = len_val;
               if (len_val == '0) begin
                  last     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            seen_in = seen_inc;
            left_in = left_dec;
            if (left_dec == '0) begin
               last     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            offset   = '0;
            phase_in = PH_IDLE;
            result.packet_kind = kind_dec;
            if (known) begin
               kind_in  = kind_dec;
               seen_in  = hcid_pkg::SEEN_W'(1);
               left_in  = '0;
               phase_in = PH_HEADER;
            end else begin
               result.in_frame    = 1'b0;
               result.packet_kind = '0;
            end
         end
      endcase
      // Position saturates at capacity minus one
      pos_full = (offset >= hcid_pkg::SEEN_CAP) ? hcid_pkg::SEEN_TOP : offset;
      if (result.in_frame) begin
         result.byte_position = hcid_pkg::POS_W'(pos_full);
         result.overflow      = (offset >= hcid_pkg::SEEN_CAP);
         result.frame_last    = last;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= hcid_pkg::KIND_CMD;
         seen_ff  <= '0;
         left_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         seen_ff  <= seen_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hcid_out_stage.sv
// Result register stage with valid/ready handshake.
// Depends on hcid_pkg for the result beat type.
`default_nettype none

module hcid_out_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire hcid_pkg::rsp_type data_in,
   output logic                 can_load,
   output logic                 valid,
   input  wire logic            ready,
   output hcid_pkg::rsp_type    data_out
);

   logic               valid_ff;
   hcid_pkg::rsp_type  data_ff;

   // Room when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || ready;
   assign valid    = valid_ff;
   assign data_out = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hci_uart_packet_deframer.sv
// HCI UART (H4) packet deframer. One received byte per beat is accepted and
// one tagged result beat per byte is returned: kind, offset in frame, last
// flag and overflow. Throughput is one byte per clock while rsp_ready stays
// high; a byte passes through the input register and then the result
// register. The rate is set by the frame state loop (phase, byte count,
// payload countdown), which updates once per byte. Bytes outside a frame
// come back with in_frame low and all tags zero.
// Depends on hcid_pkg, hcid_tracker and hcid_out_stage.
`default_nettype none

module hci_uart_packet_deframer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_in_frame,
   output logic [1:0]                       rsp_packet_kind,
   output logic [hcid_pkg::POS_W-1:0]       rsp_byte_position,
   output logic                             rsp_frame_last,
   output logic                             rsp_overflow
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               advance;
   logic               can_load;
   hcid_pkg::rsp_type  result;
   hcid_pkg::rsp_type  rsp_data;

   // Input beat moves on when the result register has room
   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   hcid_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   hcid_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .data_in  (result),
      .can_load (can_load),
      .valid    (rsp_valid),
      .ready    (rsp_ready),
      .data_out (rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_in_frame      = rsp_data.in_frame;
   assign rsp_packet_kind   = rsp_data.packet_kind;
   assign rsp_byte_position = rsp_data.byte_position;
   assign rsp_frame_last    = rsp_data.frame_last;
   assign rsp_overflow      = rsp_data.overflow;

endmodule

`default_nettype wire

FILE: sv/hcid_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on hcid_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hcid_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [7:0]                  rsp_out_byte,
   input  wire logic                        rsp_in_frame,
   input  wire logic [1:0]                  rsp_packet_kind,
   input  wire logic [hcid_pkg::POS_W-1:0]  rsp_byte_position,
   input  wire logic                        rsp_frame_last,
   input  wire logic                        rsp_overflow
);

   // A stalled result beat is held
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Dropped bytes carry no tags
   `ASSERT_IMPLY(a_drop_clean, clock, reset, rsp_valid && !rsp_in_frame, (rsp_packet_kind == 2'd0) && (rsp_byte_position == '0) && !rsp_frame_last && !rsp_overflow)

   // Overflowed beats sit at the saturated position
   `ASSERT_IMPLY(a_ovf_pos, clock, reset, rsp_valid && rsp_overflow, rsp_byte_position == hcid_pkg::POS_W'(hcid_pkg::FRAME_CAPACITY - 1))

   // The opening byte of a frame is never its last
   `ASSERT_IMPLY(a_open_not_last, clock, reset, rsp_valid && rsp_in_frame && (rsp_byte_position == '0) && !rsp_overflow, !rsp_frame_last)

endmodule

bind hci_uart_packet_deframer hcid_checker u_hcid_checker (.*);

`default_nettype wire
